FILE: design/glos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glos_pkg
// Shared types and constants for the grid line-of-sight block.
// ----------------------------------------------------------------------------
package glos_pkg;

    // Map geometry; the row stride of the bitmap is fixed at MAP_DIM
    localparam int MAP_DIM = 32;
    localparam int IDX_W   = $clog2(MAP_DIM);   // row / column index
    localparam int DIM_W   = IDX_W + 1;         // effective width / height
    localparam int ERR_W   = IDX_W + 1;         // walk error term

    // Coordinates: 7-bit signed inputs, 8-bit signed after neighbor offset
    localparam int CRD_W   = 7;
    localparam int POS_W   = CRD_W + 1;

    // Configuration port
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET  = 6'd25;

    // Stream payload layout
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int SX_LSB    = 0;
    localparam int SY_LSB    = SX_LSB + CRD_W;
    localparam int EX_LSB    = SY_LSB + CRD_W;
    localparam int EY_LSB    = EX_LSB + CRD_W;
    localparam int SEE_BIT   = EY_LSB + CRD_W;

    // Neighbor offsets, two's complement
    localparam logic [1:0] OFS_NEG  = 2'b11;
    localparam logic [1:0] OFS_ZERO = 2'b00;
    localparam logic [1:0] OFS_POS  = 2'b01;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_STRICT = 2'd1,
        REQ_LOOSE  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_CAND,
        ST_CAND_CHK,
        ST_WALK,
        ST_NEXT,
        ST_DONE
    } t_state;

    // Signed coordinate inside [0, lim)
    function automatic logic cell_in(input logic [POS_W-1:0] c, input logic [DIM_W-1:0] lim);
        return !c[POS_W-1] && (c[POS_W-2:0] < (POS_W-1)'(lim));
    endfunction

endpackage : glos_pkg
`default_nettype wire

FILE: design/grid_line_of_sight.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_line_of_sight
// Transparency bitmap of a grid with Bresenham line-of-sight queries.
//
//   channel   dir  handshake                    payload
//   s_axis    in   tvalid / tready              tdata: cell coords, bit; tuser: request
//   m_axis    out  tvalid / tready              tdata: visible, write_done
//   cfg       in   wr_en (no wait)              idx, data: map width / height
//
// Cell write: ST_WR_RD reads the row, ST_WR_WB writes it back with the cell
// changed; a write off the map goes to ST_DONE. Strict query: ST_CAND reads
// the candidate row, ST_CAND_CHK checks it and sets up the walk, ST_WALK tests
// the cells between the ends; a loose query tries up to nine candidates. Each
// tested cell costs one read of the single bitmap read port, one per cycle.
// Reset: rows of the bitmap carry valid flags, so unwritten rows read opaque
// and no clearing pass is needed; the block is idle and ready after reset.
// One item at a time; a finished result waits in the output register.
// ----------------------------------------------------------------------------
module grid_line_of_sight (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // start_x[6:0], start_y[13:7], end_x[20:14], end_y[27:21], see_through[28]
    input  wire logic [glos_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // req_type[1:0]
    input  wire logic [glos_pkg::S_TUSER_W-1:0]     i_s_axis_tuser,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // visible[0], write_done[1]
    output logic [glos_pkg::M_TDATA_W-1:0]          o_m_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [glos_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [glos_pkg::CFG_W-1:0]         i_cfg_data
);
    import glos_pkg::*;

    // ---------------- registers ----------------
    t_state                 r_state, n_state;
    logic [CFG_W-1:0]       r_map_w, r_map_h;
    logic                   r_strict, n_strict;
    logic [CRD_W-1:0]       r_sx, n_sx, r_sy, n_sy, r_ex, n_ex, r_ey, n_ey;
    logic                   r_see, n_see;
    logic                   r_wr_ok, n_wr_ok;
    logic [1:0]             r_ox, n_ox, r_oy, n_oy;
    logic [POS_W-1:0]       r_cx, n_cx, r_cy, n_cy;
    logic                   r_xmaj, n_xmaj;
    logic [IDX_W-1:0]       r_a, n_a, r_b, n_b;
    logic                   r_adir, n_adir, r_bdir, n_bdir;
    logic [IDX_W-1:0]       r_maj, n_maj, r_min, n_min;
    logic [ERR_W-1:0]       r_err, n_err;
    logic [IDX_W-1:0]       r_left, n_left;
    logic                   r_pend, n_pend;
    logic [IDX_W-1:0]       r_pend_col, n_pend_col;
    logic                   r_res_vis, n_res_vis, r_res_done, n_res_done;
    logic                   r_ov, n_ov, r_ovis, n_ovis, r_odone, n_odone;

    // ---------------- bitmap ----------------
    logic [MAP_DIM-1:0]     mem [MAP_DIM];
    logic [MAP_DIM-1:0]     r_rowv;
    logic [MAP_DIM-1:0]     r_rd_data;
    logic                   r_rd_rowv;
    logic [IDX_W-1:0]       rd_addr;
    logic                   mem_we;
    logic [MAP_DIM-1:0]     wr_row;
    logic [MAP_DIM-1:0]     rd_row;

    // ---------------- combinational ----------------
    logic                   s_acc, out_free;
    t_req                   in_req;
    logic [CRD_W-1:0]       in_sx, in_sy;
    logic [DIM_W-1:0]       eff_w, eff_h;
    logic                   in_wr_ok;
    logic [POS_W-1:0]       cand_x, cand_y;
    logic [IDX_W-1:0]       cx_i, cy_i, ex_i, ey_i, acx, acy;
    logic                   x_neg, y_neg, xmaj, adj, cand_ok, end_ok, go;
    logic                   cand_last;
    logic [IDX_W-1:0]       a_nx, b_nx, walk_row, walk_col;
    logic                   stp;
    logic [ERR_W-1:0]       err_base, err_nx;
    logic                   fail;

    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ov || i_m_axis_tready;
    assign in_req   = t_req'(i_s_axis_tuser);
    assign in_sx    = i_s_axis_tdata[SX_LSB +: CRD_W];
    assign in_sy    = i_s_axis_tdata[SY_LSB +: CRD_W];

    // Dimensions above MAP_DIM clamp to MAP_DIM
    always_comb begin
        if (32'(r_map_w) > MAP_DIM) begin
            eff_w = DIM_W'(MAP_DIM);
        end else begin
            eff_w = DIM_W'(r_map_w);
        end
        if (32'(r_map_h) > MAP_DIM) begin
            eff_h = DIM_W'(MAP_DIM);
        end else begin
            eff_h = DIM_W'(r_map_h);
        end
    end

    assign in_wr_ok = cell_in({in_sx[CRD_W-1], in_sx}, eff_w) &&
                      cell_in({in_sy[CRD_W-1], in_sy}, eff_h);

    // Unwritten rows read as all opaque
    assign rd_row = r_rd_rowv ? r_rd_data : '0;

    // Candidate start: start cell plus neighbor offset
    assign cand_x = {r_sx[CRD_W-1], r_sx} + {{(POS_W-2){r_ox[1]}}, r_ox};
    assign cand_y = {r_sy[CRD_W-1], r_sy} + {{(POS_W-2){r_oy[1]}}, r_oy};
    assign cand_last = (r_ox == OFS_POS) && (r_oy == OFS_POS);

    // Candidate check and walk setup; the setup is used only when go finds both ends in the map
    assign cx_i   = r_cx[IDX_W-1:0];
    assign cy_i   = r_cy[IDX_W-1:0];
    assign ex_i   = r_ex[IDX_W-1:0];
    assign ey_i   = r_ey[IDX_W-1:0];
    assign x_neg  = ex_i < cx_i;
    assign y_neg  = ey_i < cy_i;
    assign acx    = x_neg ? cx_i - ex_i : ex_i - cx_i;
    assign acy    = y_neg ? cy_i - ey_i : ey_i - cy_i;
    assign xmaj   = acx > acy;
    assign adj    = (acx <= IDX_W'(1)) && (acy <= IDX_W'(1));
    assign cand_ok = cell_in(r_cx, eff_w) && cell_in(r_cy, eff_h);
    assign end_ok  = cell_in({r_ex[CRD_W-1], r_ex}, eff_w) &&
                     cell_in({r_ey[CRD_W-1], r_ey}, eff_h);
    assign go = cand_ok && end_ok &&
                (((r_ox == OFS_ZERO) && (r_oy == OFS_ZERO)) || rd_row[cx_i]);

    // Bresenham step along the major axis
    assign a_nx     = r_adir ? r_a - IDX_W'(1) : r_a + IDX_W'(1);
    assign stp      = r_err >= {1'b0, r_maj};
    assign b_nx     = stp ? (r_bdir ? r_b - IDX_W'(1) : r_b + IDX_W'(1)) : r_b;
    assign err_base = stp ? r_err - {1'b0, r_maj} : r_err;
    assign err_nx   = err_base + {1'b0, r_min};
    assign walk_col = r_xmaj ? a_nx : b_nx;
    assign walk_row = r_xmaj ? b_nx : a_nx;
    assign fail     = r_pend && !rd_row[r_pend_col];

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    case (in_req)
                        REQ_WRITE:             n_state = in_wr_ok ? ST_WR_RD : ST_DONE;
                        REQ_STRICT, REQ_LOOSE: n_state = ST_CAND;
                        default:               n_state = ST_DONE;
                    endcase
                end
            end
            ST_WR_RD:    n_state = ST_WR_WB;
            ST_WR_WB:    n_state = ST_DONE;
            ST_CAND:     n_state = ST_CAND_CHK;
            ST_CAND_CHK: begin
                if (!go) begin
                    n_state = ST_NEXT;
                end else if (adj) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (fail) begin
                    n_state = ST_NEXT;
                end else if (r_left == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_NEXT:     n_state = (r_strict || cand_last) ? ST_DONE : ST_CAND;
            ST_DONE:     n_state = out_free ? ST_IDLE : ST_DONE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        n_strict   = r_strict;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_ex       = r_ex;
        n_ey       = r_ey;
        n_see      = r_see;
        n_wr_ok    = r_wr_ok;
        n_ox       = r_ox;
        n_oy       = r_oy;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_xmaj     = r_xmaj;
        n_a        = r_a;
        n_b        = r_b;
        n_adir     = r_adir;
        n_bdir     = r_bdir;
        n_maj      = r_maj;
        n_min      = r_min;
        n_err      = r_err;
        n_left     = r_left;
        n_pend     = r_pend;
        n_pend_col = r_pend_col;
        n_res_vis  = r_res_vis;
        n_res_done = r_res_done;
        n_ov       = r_ov && !i_m_axis_tready;
        n_ovis     = r_ovis;
        n_odone    = r_odone;
        rd_addr    = '0;
        mem_we     = 1'b0;
        wr_row     = rd_row;
        wr_row[r_sx[IDX_W-1:0]] = r_see;

        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_strict   = (in_req == REQ_STRICT);
                    n_sx       = in_sx;
                    n_sy       = in_sy;
                    n_ex       = i_s_axis_tdata[EX_LSB +: CRD_W];
                    n_ey       = i_s_axis_tdata[EY_LSB +: CRD_W];
                    n_see      = i_s_axis_tdata[SEE_BIT];
                    n_wr_ok    = in_wr_ok;
                    n_ox       = (in_req == REQ_STRICT) ? OFS_ZERO : OFS_NEG;
                    n_oy       = (in_req == REQ_STRICT) ? OFS_ZERO : OFS_NEG;
                    n_res_vis  = 1'b0;
                    n_res_done = 1'b0;
                end
            end
            ST_WR_RD: begin
                rd_addr = r_sy[IDX_W-1:0];
            end
            ST_WR_WB: begin
                mem_we     = 1'b1;
                n_res_done = 1'b1;
            end
            ST_CAND: begin
                n_cx    = cand_x;
                n_cy    = cand_y;
                rd_addr = cand_y[IDX_W-1:0];
            end
            ST_CAND_CHK: begin
                n_res_vis = go && adj;
                n_xmaj    = xmaj;
                n_a       = xmaj ? cx_i : cy_i;
                n_b       = xmaj ? cy_i : cx_i;
                n_adir    = xmaj ? x_neg : y_neg;
                n_bdir    = xmaj ? y_neg : x_neg;
                n_maj     = xmaj ? acx : acy;
                n_min     = xmaj ? acy : acx;
                n_err     = {1'b0, (xmaj ? acy : acx)};
                n_left    = (xmaj ? acx : acy) - IDX_W'(1);
                n_pend    = 1'b0;
            end
            ST_WALK: begin
                // issue the next cell while checking the one read last cycle
                rd_addr = walk_row;
                if (r_left != '0) begin
                    n_a        = a_nx;
                    n_b        = b_nx;
                    n_err      = err_nx;
                    n_left     = r_left - IDX_W'(1);
                    n_pend     = 1'b1;
                    n_pend_col = walk_col;
                end else begin
                    n_pend = 1'b0;
                end
                if (!fail && r_left == '0) begin
                    n_res_vis = 1'b1;
                end
            end
            ST_NEXT: begin
                if (r_ox == OFS_POS) begin
                    n_ox = OFS_NEG;
                    n_oy = r_oy + 2'd1;
                end else begin
                    n_ox = r_ox + 2'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ovis  = r_res_vis;
                    n_odone = r_res_done;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_map_w <= CFG_DIM_RESET;
            r_map_h <= CFG_DIM_RESET;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
            r_rowv  <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_pend  <= n_pend;
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_MAP_WIDTH:  r_map_w <= i_cfg_data;
                    CFG_MAP_HEIGHT: r_map_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (mem_we) begin
                r_rowv[r_sy[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_strict   <= n_strict;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_ex       <= n_ex;
        r_ey       <= n_ey;
        r_see      <= n_see;
        r_wr_ok    <= n_wr_ok;
        r_ox       <= n_ox;
        r_oy       <= n_oy;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_xmaj     <= n_xmaj;
        r_a        <= n_a;
        r_b        <= n_b;
        r_adir     <= n_adir;
        r_bdir     <= n_bdir;
        r_maj      <= n_maj;
        r_min      <= n_min;
        r_err      <= n_err;
        r_left     <= n_left;
        r_pend_col <= n_pend_col;
        r_res_vis  <= n_res_vis;
        r_res_done <= n_res_done;
        r_ovis     <= n_ovis;
        r_odone    <= n_odone;
    end

    // Bitmap: one row per entry, registered read, read-modify-write for cell writes
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_sy[IDX_W-1:0]] <= wr_row;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_rowv <= r_rowv[rd_addr];
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {(M_TDATA_W - 2)'(0), r_odone, r_ovis};

    // ---------------- assertions ----------------
    a_res_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(r_ovis && r_odone))
        else $error("visible and write_done both set");

    a_walk_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_maj > IDX_W'(1)))
        else $error("walk entered for adjacent cells");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == ST_DONE))
        else $error("result beat raised outside completion");

    a_wb_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR_WB) |-> r_wr_ok)
        else $error("bitmap write for a cell outside the map");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("second beat taken while an item is in flight");

endmodule : grid_line_of_sight
`default_nettype wire

FILE: test/glos_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glos_checker
// Watches the request, result and register channels of grid_line_of_sight.
// Keeps its own copy of the transparency bitmap and the map size, works out
// the result of every accepted request beat and compares it, in order, with
// the result beats the block hands out.
// ----------------------------------------------------------------------------
module glos_checker
    import glos_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic [S_TUSER_W-1:0]  i_s_tuser,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output int                    o_mismatches,
    output int                    o_results
);

    localparam int VIS_BIT  = 0;
    localparam int DONE_BIT = 1;

    typedef struct packed {
        logic write_done;
        logic visible;
    } t_outcome;

    bit [MAP_DIM*MAP_DIM-1:0] clear_bits;
    int                       map_w;
    int                       map_h;
    t_outcome                 outcome_q[$];
    t_outcome                 want;
    t_outcome                 got;
    int                       mismatches = 0;
    int                       results    = 0;

    assign o_mismatches = mismatches;
    assign o_results    = results;

    function automatic int clip_dim(input int d);
        return d > MAP_DIM ? MAP_DIM : d;
    endfunction

    function automatic bit on_map(input int x, input int y);
        return x >= 0 && x < clip_dim(map_w) && y >= 0 && y < clip_dim(map_h);
    endfunction

    // cells off the map are opaque
    function automatic bit see_cell(input int x, input int y);
        if (!on_map(x, y))
            return 1'b0;
        return clear_bits[y*MAP_DIM + x];
    endfunction

    function automatic bit strict_sight(input int sx, input int sy, input int ex, input int ey);
        int ddx, ddy, spanx, spany, stx, sty, x, y, err;
        ddx   = ex - sx;
        ddy   = ey - sy;
        spanx = ddx < 0 ? -ddx : ddx;
        spany = ddy < 0 ? -ddy : ddy;
        stx   = ddx > 0 ? 1 : (ddx < 0 ? -1 : 0);
        sty   = ddy > 0 ? 1 : (ddy < 0 ? -1 : 0);
        if (!on_map(sx, sy) || !on_map(ex, ey))
            return 1'b0;
        if (spanx <= 1 && spany <= 1)
            return 1'b1;
        // end points are never tested, only the cells between them
        if (spanx > spany) begin
            err = spany;
            y   = sy;
            for (x = sx + stx; x != ex; x += stx) begin
                if (err >= spanx) begin
                    err -= spanx;
                    y   += sty;
                end
                if (!see_cell(x, y))
                    return 1'b0;
                err += spany;
            end
        end else begin
            err = spanx;
            x   = sx;
            for (y = sy + sty; y != ey; y += sty) begin
                if (err >= spany) begin
                    err -= spany;
                    x   += stx;
                end
                if (!see_cell(x, y))
                    return 1'b0;
                err += spanx;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit loose_sight(input int sx, input int sy, input int ex, input int ey);
        for (int oy = -1; oy <= 1; oy++) begin
            for (int ox = -1; ox <= 1; ox++) begin
                if ((ox == 0 && oy == 0) || see_cell(sx + ox, sy + oy)) begin
                    if (strict_sight(sx + ox, sy + oy, ex, ey))
                        return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // also updates the bitmap for a cell write
    function automatic t_outcome apply_request(input logic [S_TUSER_W-1:0] req,
                                               input logic [S_TDATA_W-1:0] data);
        t_outcome r;
        int sx, sy, ex, ey;
        sx = int'($signed(data[SX_LSB +: CRD_W]));
        sy = int'($signed(data[SY_LSB +: CRD_W]));
        ex = int'($signed(data[EX_LSB +: CRD_W]));
        ey = int'($signed(data[EY_LSB +: CRD_W]));
        r  = '0;
        case (req)
            REQ_WRITE: begin
                if (on_map(sx, sy)) begin
                    clear_bits[sy*MAP_DIM + sx] = data[SEE_BIT];
                    r.write_done = 1'b1;
                end
            end
            REQ_STRICT: r.visible = strict_sight(sx, sy, ex, ey);
            REQ_LOOSE:  r.visible = loose_sight(sx, sy, ex, ey);
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_bits = '0;
            map_w      = int'(CFG_DIM_RESET);
            map_h      = int'(CFG_DIM_RESET);
            outcome_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_MAP_WIDTH:  map_w = int'(i_cfg_data);
                    CFG_MAP_HEIGHT: map_h = int'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                outcome_q.push_back(apply_request(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                results <= results + 1;
                got.visible    = i_m_tdata[VIS_BIT];
                got.write_done = i_m_tdata[DONE_BIT];
                if (outcome_q.size() == 0) begin
                    $error("result beat with no request outstanding");
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got.visible !== want.visible) begin
                        $error("visible: expected %0d, got %0b", want.visible, got.visible);
                        mismatches++;
                    end
                    if (got.write_done !== want.write_done) begin
                        $error("write_done: expected %0d, got %0b",
                               want.write_done, got.write_done);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for grid_line_of_sight: a directed set of cell writes and queries
// at the reset map size, then random phases at several map sizes, with most
// traffic packed into a small window so that lines cross written cells.
// Both stream sides stall at random outside the calm phase; glos_checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
    import glos_pkg::*;

    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 95;
    localparam int CALM_PHASE   = 1;
    localparam int WINDOW       = 8;
    localparam int DRAIN_CYCLES = 400;

    localparam int MODE_FOCUS = 0;
    localparam int MODE_WIDE  = 1;
    localparam int MODE_ANY   = 2;

    localparam logic [S_TUSER_W-1:0] REQ_UNUSED = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx     = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;

    int mismatches;
    int results_seen;
    int sent_cnt = 0;
    bit calm     = 1'b0;
    int cur_w    = int'(CFG_DIM_RESET);
    int cur_h    = int'(CFG_DIM_RESET);
    int org_x    = 0;
    int org_y    = 0;

    int phase_w[PHASES] = '{32, 63, 1, 0, 12, 32, 1, 17, 33, 25};
    int phase_h[PHASES] = '{32, 40, 1, 17, 0, 1, 32, 9, 63, 25};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk)
        m_tready <= calm || ($urandom_range(99) >= 26);

    grid_line_of_sight u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    glos_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_results    (results_seen)
    );

    // one request beat; tvalid stays up afterwards unless the next beat idles
    task automatic send_req(input logic [S_TUSER_W-1:0] req, input int sx, input int sy,
                            input int ex, input int ey, input bit see);
        logic [S_TDATA_W-1:0] beat;
        beat                     = '0;
        beat[SX_LSB +: CRD_W]    = CRD_W'(sx);
        beat[SY_LSB +: CRD_W]    = CRD_W'(sy);
        beat[EX_LSB +: CRD_W]    = CRD_W'(ex);
        beat[EY_LSB +: CRD_W]    = CRD_W'(ey);
        beat[SEE_BIT]            = see;
        while (!calm && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tdata  <= beat;
        s_tuser  <= req;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        sent_cnt++;
    endtask

    // drop tvalid and wait until every result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_seen != sent_cnt)
            @(posedge i_clk);
    endtask

    task automatic set_dims(input int w, input int h);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_idx   <= CFG_MAP_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(posedge i_clk);
        cfg_idx   <= CFG_MAP_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    function automatic int pick_coord(input int mode, input int org, input int dim);
        int e;
        e = dim > MAP_DIM ? MAP_DIM : dim;
        case (mode)
            MODE_FOCUS: return org + $urandom_range(WINDOW - 1);
            MODE_WIDE:  return $urandom_range(e + 3) - 2;
            default:    return $urandom_range(127) - 64;
        endcase
    endfunction

    function automatic int pick_origin(input int dim);
        int e;
        e = dim > MAP_DIM ? MAP_DIM : dim;
        return e > WINDOW ? $urandom_range(e - WINDOW) : 0;
    endfunction

    task automatic random_item();
        int r, m;
        logic [S_TUSER_W-1:0] req;
        r = $urandom_range(99);
        m = $urandom_range(99);
        if (r < 34)
            req = REQ_WRITE;
        else if (r < 64)
            req = REQ_STRICT;
        else if (r < 96)
            req = REQ_LOOSE;
        else
            req = REQ_UNUSED;
        m = m < 75 ? MODE_FOCUS : (m < 95 ? MODE_WIDE : MODE_ANY);
        send_req(req, pick_coord(m, org_x, cur_w), pick_coord(m, org_y, cur_h),
                 pick_coord(m, org_x, cur_w), pick_coord(m, org_y, cur_h),
                 $urandom_range(99) < 80);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset map size 25 x 25, row 2 opened up for a clear line
        for (int x = 0; x <= 4; x++)
            send_req(REQ_WRITE, x, 2, 0, 0, 1'b1);
        send_req(REQ_STRICT, 0, 2, 5, 2, 1'b0);
        send_req(REQ_STRICT, 0, 3, 5, 2, 1'b0);
        send_req(REQ_LOOSE, 0, 3, 5, 2, 1'b0);         // only a neighbor sees through
        send_req(REQ_STRICT, 3, 3, 3, 3, 1'b1);        // same cell
        send_req(REQ_STRICT, 10, 10, 11, 9, 1'b0);     // touching, both opaque
        send_req(REQ_STRICT, -1, 0, 0, 5, 1'b0);       // start off the map
        send_req(REQ_STRICT, 0, 0, 25, 0, 1'b0);       // end off the map
        send_req(REQ_WRITE, 25, 0, 0, 0, 1'b1);        // write off the map
        send_req(REQ_WRITE, -64, -64, 63, 63, 1'b1);
        send_req(REQ_WRITE, 24, 24, -64, -64, 1'b1);
        send_req(REQ_STRICT, 63, 63, -64, -64, 1'b1);
        send_req(REQ_STRICT, 2, 0, 3, 6, 1'b0);        // steep line
        send_req(REQ_STRICT, 0, 0, 4, 4, 1'b0);        // exact diagonal
        send_req(REQ_LOOSE, 24, 24, 20, 24, 1'b1);     // corner start
        send_req(REQ_UNUSED, 63, -64, 63, -64, 1'b1);
        send_req(REQ_WRITE, 2, 2, 0, 0, 1'b0);         // close the row again
        send_req(REQ_STRICT, 0, 2, 5, 2, 1'b0);
        send_req(REQ_LOOSE, -1, 2, 5, 2, 1'b0);        // start off map, neighbor on it

        for (int p = 0; p < PHASES; p++) begin
            set_dims(phase_w[p], phase_h[p]);
            calm = (p == CALM_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 32 == 0) begin
                    org_x = pick_origin(cur_w);
                    org_y = pick_origin(cur_h);
                end
                random_item();
            end
            calm = 1'b0;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_seen == sent_cnt)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
